FILE: rtl/core/pgst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgst_pkg
// Shared types, constants and the exponential table for the
// position-gated stimulation trigger.
// ----------------------------------------------------------------------------
package pgst_pkg;

  localparam int ZONE_SLOTS_DEF      = 8;
  localparam int COORD_BITS_DEF      = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // Operation codes of an input item.
  localparam logic [1:0] OP_POS   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_CHANNEL = 3'd1;
  localparam logic [2:0] REG_UNIFORM = 3'd2;
  localparam logic [2:0] REG_BASE    = 3'd3;
  localparam logic [2:0] REG_SCALE   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [2:0]  zone_index;
    logic [15:0] zone_x;
    logic [15:0] zone_y;
    logic [15:0] zone_radius;
    logic        zone_valid;
  } in_item_t;

  typedef struct packed {
    logic        trigger;
    logic [1:0]  trigger_channel;
    logic        inside_zone;
    logic [2:0]  hit_index;
    logic [15:0] interval_ms;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the input item, apply position or zone write
    logic clr_scan;  // clear hit state and start the zone walk
    logic zone_step; // test the current zone slot
    logic sq_step;   // square phase select
    logic exp_step;  // form the exponent product
    logic rom_step;  // read the table
    logic int_step;  // scale base period by the entry
    logic fin_step;  // tick count and trigger decision
  } cmd_t;

  typedef struct packed {
    logic last_zone;
  } sts_t;

  // exp(2*i/depth) in Q4.16, by an integer Taylor series in Q4.28.
  function automatic logic [31:0] exp_entry(input int unsigned idx, input int unsigned depth);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] sh;
    x    = (64'(idx) << 29) / 64'(depth);
    term = 64'd1 << 28;
    sum  = term;
    for (int k = 1; k <= 48; k++) begin
      if (term != 64'd0) begin
        sh   = (term * x) >> 28;
        term = sh / 64'(k);
        sum  = sum + term;
      end
    end
    return 32'((sum + 64'd2048) >> 12);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pgst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgst_ctrl
// Sequencer: walks the zone slots with a square step and a compare step each,
// then runs the interval steps and presents the result.
// ----------------------------------------------------------------------------
module pgst_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  pgst_pkg::sts_t      sts_i,
  output pgst_pkg::cmd_t      cmd_o
);
  import pgst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_ROM  = 3'd4;
  localparam logic [2:0] S_INT  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d        = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        cmd_o.zone_step = 1'b1;
        state_d         = sts_i.last_zone ? S_EXP : S_SQ;
      end
      S_EXP: begin
        cmd_o.exp_step = 1'b1;
        state_d        = S_ROM;
      end
      S_ROM: begin
        cmd_o.rom_step = 1'b1;
        state_d        = S_INT;
      end
      S_INT: begin
        cmd_o.int_step = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin_step = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pgst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgst_dp
// Datapath: zone store, position, squared distance unit, exponent table,
// interval scaling and the millisecond counter.
// ----------------------------------------------------------------------------
module pgst_dp #(
  parameter int ZONE_SLOTS      = pgst_pkg::ZONE_SLOTS_DEF,
  parameter int COORD_BITS      = pgst_pkg::COORD_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = pgst_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pgst_pkg::in_item_t  item_i,
  input  pgst_pkg::cmd_t      cmd_i,
  output pgst_pkg::sts_t      sts_o,
  input  wire                 enable_i,
  input  wire                 uniform_i,
  input  wire [15:0]          base_i,
  input  wire [15:0]          scale_i,
  output logic                trigger_o,
  output logic                inside_o,
  output logic [2:0]          hit_o,
  output logic [15:0]         interval_o
);
  import pgst_pkg::*;

  localparam int ZW  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int D2W = 2 * COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS;
  localparam int EW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
  localparam int PW  = D2W - COORD_BITS + 16;
  localparam int IW  = PW + EW;

  // Zone store in flip-flops, valid bits cleared by reset.
  logic [COORD_BITS-1:0] zx_q [ZONE_SLOTS];
  logic [COORD_BITS-1:0] zy_q [ZONE_SLOTS];
  logic [COORD_BITS-1:0] zr_q [ZONE_SLOTS];
  logic [ZONE_SLOTS-1:0] zv_q;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic                  known_q;
  logic [1:0]            op_q;
  logic [ZW-1:0]         slot_q;
  logic                  inside_q;
  logic [2:0]            hit_q;
  logic [D2W-1:0]        hit_d2_q;
  logic [D2W-1:0]        d2_q;
  logic [D2W-1:0]        r2_q;
  logic [PW-1:0]         p_q;
  logic [31:0]           ent_q;
  logic [15:0]           int_q;
  logic [31:0]           elapsed_q;
  logic                  trig_q;

  logic [COORD_BITS-1:0] px, py;
  logic                  zi_ok;
  logic [ZW-1:0]         zi;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQW-1:0]        dx2, dy2, rr2;
  logic [IW-1:0]         idx_full;
  logic [EW-1:0]         rom_idx;
  logic [31:0]           exp_rom [EXP_TABLE_DEPTH];
  logic [48:0]           prod;
  logic [32:0]           scaled;
  logic [31:0]           elapsed_inc;

  assign px    = COORD_BITS'(item_i.pos_x);
  assign py    = COORD_BITS'(item_i.pos_y);
  assign zi    = ZW'(item_i.zone_index);
  assign zi_ok = (32'(item_i.zone_index) < ZONE_SLOTS);
  assign sts_o.last_zone = (32'(slot_q) == ZONE_SLOTS - 1);

  // Absolute coordinate differences for the slot under test.
  assign dx = (cx_q >= zx_q[slot_q]) ? cx_q - zx_q[slot_q] : zx_q[slot_q] - cx_q;
  assign dy = (cy_q >= zy_q[slot_q]) ? cy_q - zy_q[slot_q] : zy_q[slot_q] - cy_q;

  // Full-width squares of the differences and of the radius.
  assign dx2 = SQW'(dx) * SQW'(dx);
  assign dy2 = SQW'(dy) * SQW'(dy);
  assign rr2 = SQW'(zr_q[slot_q]) * SQW'(zr_q[slot_q]);

  // Constant exponential table, one entry per index.
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp_rom
    assign exp_rom[g] = exp_entry(g, EXP_TABLE_DEPTH);
  end

  // Table index from the exponent, saturated at the last entry.
  assign idx_full = (IW'(p_q) << EW) >> (COORD_BITS + 17);
  assign rom_idx  = (idx_full > IW'(EXP_TABLE_DEPTH - 1)) ? EW'(EXP_TABLE_DEPTH - 1)
                                                         : EW'(idx_full);
  assign prod     = 49'(base_i) * 49'(ent_q);
  assign scaled   = 33'((prod + 49'd32768) >> 16);
  assign elapsed_inc = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zv_q      <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      known_q   <= 1'b0;
      elapsed_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (item_i.op == OP_POS && px != '0 && py != '0) begin
          cx_q    <= px;
          cy_q    <= py;
          known_q <= 1'b1;
        end
        if (item_i.op == OP_WRITE && zi_ok) begin
          zv_q[zi] <= item_i.zone_valid;
        end
      end
      if (cmd_i.fin_step && op_q == OP_TICK) begin
        if (enable_i && inside_q && 32'(int_q) <= elapsed_inc) begin
          elapsed_q <= '0;
        end else begin
          elapsed_q <= elapsed_inc;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= item_i.op;
      if (item_i.op == OP_WRITE && zi_ok) begin
        zx_q[zi] <= COORD_BITS'(item_i.zone_x);
        zy_q[zi] <= COORD_BITS'(item_i.zone_y);
        zr_q[zi] <= COORD_BITS'(item_i.zone_radius);
      end
    end
    if (cmd_i.clr_scan) begin
      slot_q   <= '0;
      inside_q <= 1'b0;
      hit_q    <= '0;
      hit_d2_q <= '0;
    end
    // Squares in one step, one compare per slot.
    if (cmd_i.sq_step) begin
      d2_q <= D2W'(dx2) + D2W'(dy2);
      r2_q <= D2W'(rr2);
    end
    if (cmd_i.zone_step) begin
      if (known_q && zv_q[slot_q] && d2_q <= r2_q) begin
        inside_q <= 1'b1;
        hit_q    <= 3'(slot_q);
        hit_d2_q <= d2_q;
      end
      slot_q <= slot_q + ZW'(1);
    end
    if (cmd_i.exp_step) begin
      p_q <= PW'(hit_d2_q >> COORD_BITS) * PW'(scale_i);
    end
    if (cmd_i.rom_step) begin
      ent_q <= exp_rom[rom_idx];
    end
    if (cmd_i.int_step) begin
      if (inside_q && !uniform_i) begin
        int_q <= (scaled > 33'hFFFF) ? 16'hFFFF : 16'(scaled);
      end else begin
        int_q <= base_i;
      end
    end
    if (cmd_i.fin_step) begin
      trig_q <= (op_q == OP_TICK) && enable_i && inside_q &&
                (32'(int_q) <= elapsed_inc);
    end
  end

  assign trigger_o  = trig_q;
  assign inside_o   = inside_q;
  assign hit_o      = hit_q;
  assign interval_o = int_q;

endmodule
`default_nettype wire

FILE: rtl/core/position_gated_stim_trigger_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// position_gated_stim_trigger_core
// Zone-gated stimulation trigger with uniform or gaussian interval.
// ----------------------------------------------------------------------------
// Each accepted item yields one result. The zone walk shares one squaring step
// and one compare per slot, then exponent, table read, scaling and the tick
// decision run in turn. One item is in flight at a time; configuration is to
// be written only while idle, and the block itself does not enforce this.
module position_gated_stim_trigger_core #(
  parameter int ZONE_SLOTS      = pgst_pkg::ZONE_SLOTS_DEF,
  parameter int COORD_BITS      = pgst_pkg::COORD_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = pgst_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  pgst_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output pgst_pkg::out_item_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire [2:0]            cfg_index_i,
  input  wire [15:0]           cfg_data_i
);
  import pgst_pkg::*;

  logic        enable_q, uniform_q;
  logic [1:0]  channel_q;
  logic [15:0] base_q, scale_q;
  cmd_t        cmd;
  sts_t        sts;
  logic        trig, in_zone;
  logic [2:0]  hit;
  logic [15:0] interval;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      channel_q <= 2'd0;
      uniform_q <= 1'b1;
      base_q    <= 16'd100;
      scale_q   <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLE:  enable_q  <= cfg_data_i[0];
        REG_CHANNEL: channel_q <= cfg_data_i[1:0];
        REG_UNIFORM: uniform_q <= cfg_data_i[0];
        REG_BASE:    base_q    <= cfg_data_i;
        REG_SCALE:   scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pgst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pgst_dp #(
    .ZONE_SLOTS(ZONE_SLOTS), .COORD_BITS(COORD_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .enable_i(enable_q), .uniform_i(uniform_q), .base_i(base_q),
    .scale_i(scale_q), .trigger_o(trig), .inside_o(in_zone), .hit_o(hit),
    .interval_o(interval)
  );

  assign out_data_o.trigger         = trig;
  assign out_data_o.trigger_channel = channel_q;
  assign out_data_o.inside_zone     = in_zone;
  assign out_data_o.hit_index       = hit;
  assign out_data_o.interval_ms     = interval;

endmodule
`default_nettype wire

FILE: rtl/core/pgst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgst_checker
// Port-level checks of the trigger core, bound to the top level.
// ----------------------------------------------------------------------------
module pgst_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_stall_o,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input pgst_pkg::out_item_t  out_data_o
);
  import pgst_pkg::*;

  // A trigger is only reported inside a zone.
  a_trig_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger |-> out_data_o.inside_zone)
    else $error("trigger outside zone");

  // Outside every zone the hit index reads zero.
  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_zone |-> out_data_o.hit_index == 3'd0)
    else $error("hit index without zone");

  // An accepted input is not taken again while its result is pending.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted");

  // A result is not shown while the input side is open.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result while idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind position_gated_stim_trigger_core pgst_checker u_pgst_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_data_o
);
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position-gated stimulation trigger. A local
// model of the zone table, tracked position and millisecond counter predicts
// the result of every transfer, which is compared field by field with the
// block's output while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pgst_pkg::*;

  localparam int SLOTS = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Model state.
  logic m_enable;
  logic [1:0] m_channel;
  logic m_uniform;
  logic [15:0] m_base, m_scale;
  logic [15:0] zn_x [SLOTS];
  logic [15:0] zn_y [SLOTS];
  logic [15:0] zn_r [SLOTS];
  logic zn_v [SLOTS];
  logic [15:0] cur_x, cur_y;
  logic pos_known;
  logic [31:0] elapsed;

  out_item_t pending_results[$];
  int mismatches = 0;
  bit stall_busy = 1'b1;

  always #4 clk_i = ~clk_i;

  position_gated_stim_trigger_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Table entry exp(2*i/256) in Q4.16 by a truncating Taylor series.
  function automatic logic [31:0] exp_value(input logic [63:0] idx);
    logic [63:0] x, term, sum;
    x = (idx << 29) / 64'd256;
    term = 64'd1 << 28;
    sum = term;
    for (int k = 1; k <= 48; k++) begin
      if (term != 0) begin
        term = ((term * x) >> 28) / 64'(k);
        sum += term;
      end
    end
    return 32'((sum + 64'd2048) >> 12);
  endfunction

  // Advance the trigger model by one item and return its result.
  function automatic out_item_t trigger_step(input in_item_t it);
    out_item_t res;
    logic in_zone;
    logic [2:0] hit;
    logic [63:0] hit_d2, d2, r2, dx, dy, p, idx, ivl;
    logic fire;
    in_zone = 0; hit = 0; hit_d2 = 0; fire = 0;
    if (it.op == OP_POS) begin
      if (it.pos_x != 0 && it.pos_y != 0) begin
        cur_x = it.pos_x; cur_y = it.pos_y; pos_known = 1;
      end
    end else if (it.op == OP_WRITE) begin
      zn_x[it.zone_index] = it.zone_x;
      zn_y[it.zone_index] = it.zone_y;
      zn_r[it.zone_index] = it.zone_radius;
      zn_v[it.zone_index] = it.zone_valid;
    end
    if (pos_known) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (zn_v[i]) begin
          dx = cur_x >= zn_x[i] ? 64'(cur_x - zn_x[i]) : 64'(zn_x[i] - cur_x);
          dy = cur_y >= zn_y[i] ? 64'(cur_y - zn_y[i]) : 64'(zn_y[i] - cur_y);
          d2 = dx * dx + dy * dy;
          r2 = 64'(zn_r[i]) * 64'(zn_r[i]);
          if (d2 <= r2) begin
            in_zone = 1; hit = 3'(i); hit_d2 = d2;
          end
        end
      end
    end
    ivl = 64'(m_base);
    if (in_zone && !m_uniform) begin
      p = (hit_d2 >> 16) * 64'(m_scale);
      idx = (p * 64'd256) >> 33;
      if (idx > 255) idx = 255;
      ivl = (64'(m_base) * 64'(exp_value(idx)) + 64'd32768) >> 16;
      if (ivl > 64'hFFFF) ivl = 64'hFFFF;
    end
    if (it.op == OP_TICK) begin
      if (elapsed != 32'hFFFF_FFFF) elapsed++;
      if (m_enable && in_zone && 64'(elapsed) >= ivl) begin
        fire = 1; elapsed = 0;
      end
    end
    res.trigger = fire;
    res.trigger_channel = m_channel;
    res.inside_zone = in_zone;
    res.hit_index = hit;
    res.interval_ms = ivl[15:0];
    return res;
  endfunction

  // Send one transfer, with a random gap now and then, and queue its result.
  // Valid stays high after the transfer until the next item or an idle phase.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    pending_results.insert(pending_results.size(), trigger_step(it));
    @(negedge clk_i);
  endtask

  // Write one register once everything in flight has drained.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE: m_enable = val[0];
      REG_CHANNEL: m_channel = val[1:0];
      REG_UNIFORM: m_uniform = val[0];
      REG_BASE: m_base = val;
      REG_SCALE: m_scale = val;
      default: ;
    endcase
  endtask

  // Fully random item, every field filled.
  function automatic in_item_t rand_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t pos_item(input logic [15:0] x, input logic [15:0] y);
    in_item_t it;
    it = rand_item();
    it.op = OP_POS; it.pos_x = x; it.pos_y = y;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = rand_item();
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic in_item_t zone_item(input logic [2:0] i, input logic [15:0] x,
                                         input logic [15:0] y, input logic [15:0] r,
                                         input logic v);
    in_item_t it;
    it = rand_item();
    it.op = OP_WRITE; it.zone_index = i; it.zone_x = x; it.zone_y = y;
    it.zone_radius = r; it.zone_valid = v;
    return it;
  endfunction

  // Extremes, ignored coordinates, every operation and the unused code.
  task automatic test_directed();
    in_item_t it;
    send_item(tick_item());
    send_item(zone_item(3'd0, 16'h8000, 16'h8000, 16'hFFFF, 1'b1));
    send_item(tick_item());
    send_item(pos_item(16'h0000, 16'h1234));
    send_item(pos_item(16'h1234, 16'h0000));
    send_item(pos_item(16'hFFFF, 16'hFFFF));
    send_item(zone_item(3'd7, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
    send_item(pos_item(16'h0001, 16'h0001));
    send_item(zone_item(3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_BASE, 16'd0);
    write_reg(REG_CHANNEL, 16'd3);
    repeat (3) send_item(tick_item());
    it = tick_item(); it.op = 2'd3;
    send_item(it);
    write_reg(REG_UNIFORM, 16'd0);
    write_reg(REG_SCALE, 16'hFFFF);
    write_reg(REG_BASE, 16'hFFFF);
    send_item(pos_item(16'hFFFF, 16'hFFFF));
    send_item(tick_item());
    write_reg(REG_BASE, 16'd1);
    send_item(tick_item());
  endtask

  // Random settings, then walks with zone edits and many ticks.
  task automatic test_random();
    in_item_t it;
    logic [15:0] cx, cy;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_ENABLE, 16'($urandom_range(0, 3) != 0));
      write_reg(REG_CHANNEL, 16'($urandom_range(0, 3)));
      write_reg(REG_UNIFORM, 16'($urandom_range(0, 1)));
      write_reg(REG_BASE, phase == 5 ? 16'hFFFF : 16'($urandom_range(0, 12)));
      write_reg(REG_SCALE, phase == 4 ? 16'd0 : 16'($urandom));
      stall_busy = (phase != 2);
      cx = 16'($urandom_range(16'h2000, 16'hE000));
      cy = 16'($urandom_range(16'h2000, 16'hE000));
      for (int n = 0; n < 90; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            cx = cx + 16'($signed($urandom_range(0, 4096)) - 2048);
            cy = cy + 16'($signed($urandom_range(0, 4096)) - 2048);
            it = pos_item(cx, cy);
            if ($urandom_range(0, 15) == 0) it.pos_x = 0;
          end
          3: it = zone_item(3'($urandom), cx + 16'($urandom_range(0, 8191)) - 16'd4096,
                            cy + 16'($urandom_range(0, 8191)) - 16'd4096,
                            16'($urandom_range(0, 16'h3000)), $urandom_range(0, 4) != 0);
          9: it = rand_item();
          default: it = tick_item();
        endcase
        send_item(it);
      end
    end
  endtask

  // Receiver stall pattern: runs of stall and free cycles of random length.
  always @(negedge clk_i) begin
    if (stall_busy && $urandom_range(0, 3) == 0) out_stall <= ~out_stall;
    else if (!stall_busy) out_stall <= 1'b0;
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    m_enable = 0; m_channel = 0; m_uniform = 1; m_base = 100; m_scale = 0;
    for (int i = 0; i < SLOTS; i++) begin
      zn_x[i] = 0; zn_y[i] = 0; zn_r[i] = 0; zn_v[i] = 0;
    end
    cur_x = 0; cur_y = 0; pos_known = 0; elapsed = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[position_gated_stim_trigger_core] OK");
    end else begin
      $display("[position_gated_stim_trigger_core] ERROR");
    end
    $finish;
  end

  // Time limit well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("[position_gated_stim_trigger_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/pgst_pkg.sv
rtl/core/pgst_ctrl.sv
rtl/core/pgst_dp.sv
rtl/core/position_gated_stim_trigger_core.sv
rtl/core/pgst_checker.sv
test/testbench.sv
